// ===== hdl/ptpq_pkg.sv =====
package ptpq_pkg;
   localparam int QueueDepth = 16;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int TimeW = 26;

   typedef enum logic [2:0] {
      ACT_ENQ   = 3'd0,
      ACT_PURGE = 3'd1,
      ACT_TICK  = 3'd2,
      ACT_START = 3'd3,
      ACT_DONE  = 3'd4
   } action_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [23:0] dur;
      logic        once;
      logic [1:0]  own;
      logic [1:0]  prio;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] id;
      logic       once;
      logic [1:0] own;
      logic       dropped;
      logic       ended;
      logic       started;
   } status_type;
endpackage

// ===== hdl/priority_tagged_play_queue.sv =====
// One request yields one response. Enqueue, purge and start-next walk the job
// memory one entry per cycle through a single-read, single-write RAM with a
// registered read, so their time grows with the number of queued jobs. An
// enqueue that inserts at the head costs one extra write. A full or
// empty-queue enqueue, tick, set-done and unused actions do not walk the
// memory. A new request is taken only after the response to the last one is
// accepted: the memory walk sets the rate, and a response that waits for
// rsp_ready holds the input off for as long as it waits.
module priority_tagged_play_queue import ptpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_action,
   input  logic [7:0]        req_anim_id,
   input  logic [23:0]       req_duration_ms,
   input  logic              req_play_once,
   input  logic [1:0]        req_owner,
   input  logic [1:0]        req_priority_req,
   input  logic [15:0]       req_elapsed_ms,
   input  logic              req_done_flag,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_active_valid,
   output logic [7:0]        rsp_active_id,
   output logic              rsp_active_play_once,
   output logic [1:0]        rsp_active_owner,
   output logic [4:0]        rsp_queue_count,
   output logic              rsp_dropped,
   output logic              rsp_ended,
   output logic              rsp_started
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WALK = 5'b00010,
      S_TAIL = 5'b00100,
      S_DONE = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   action_type act_ff, act_in;
   job_type new_ff, new_in;
   logic [1:0] purge_own_ff, purge_own_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] rptr_ff, rptr_in;
   logic [CntW-1:0] wptr_ff, wptr_in;
   logic slot_valid_ff, slot_valid_in;
   job_type slot_ff, slot_in;
   logic signed [TimeW-1:0] time_ff, time_in;
   logic done_mark_ff, done_mark_in;
   status_type st_ff, st_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   job_type wr_data, rd_data;
   job_type req_job;
   logic last_entry;

   ptpq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   localparam logic signed [TimeW:0] TimeFloor = $signed({2'b11, {(TimeW - 1){1'b0}}});
   logic signed [TimeW:0] tsub;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rd_addr = rptr_in[IdxW-1:0];
   assign req_job = {req_anim_id, req_duration_ms, req_play_once, req_owner,
                     req_priority_req};
   assign last_entry = (rptr_ff == cnt_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      new_in = new_ff;
      purge_own_in = purge_own_ff;
      cnt_in = cnt_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      slot_valid_in = slot_valid_ff;
      slot_in = slot_ff;
      time_in = time_ff;
      done_mark_in = done_mark_ff;
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = wptr_ff[IdxW-1:0];
      wr_data = rd_data;
      tsub = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               act_in = action_type'(req_action);
               new_in = req_job;
               purge_own_in = req_owner;
               st_in = '0;
               rptr_in = '0;
               wptr_in = '0;
               state_in = S_DONE;
               unique case (req_action)
                  ACT_ENQ: begin
                     if (cnt_ff >= CntW'(QueueDepth)) begin
                        st_in.dropped = 1'b1;
                     end else if (cnt_ff == '0) begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data = req_job;
                        cnt_in = CntW'(1);
                     end else begin
                        rptr_in = cnt_ff - 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  ACT_PURGE: begin
                     if (cnt_ff != '0) state_in = S_WALK;
                     if (slot_valid_ff && slot_ff.own == req_owner) begin
                        slot_valid_in = 1'b0;
                        slot_in = '0;
                        time_in = '0;
                        done_mark_in = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (slot_valid_ff) begin
                        tsub = {time_ff[TimeW-1], time_ff} - $signed({11'd0, req_elapsed_ms});
                        if (tsub < TimeFloor) tsub = TimeFloor;
                        time_in = tsub[TimeW-1:0];
                        if (tsub <= 0 || done_mark_ff) begin
                           slot_valid_in = 1'b0;
                           done_mark_in = 1'b0;
                           st_in.ended = 1'b1;
                        end
                     end
                  end
                  ACT_START: begin
                     if (!slot_valid_ff && cnt_ff != '0) begin
                        state_in = S_WALK;
                        st_in.started = 1'b1;
                     end
                  end
                  ACT_DONE: done_mark_in = req_done_flag;
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            // rd_data holds entry rptr_ff
            unique case (act_ff)
               ACT_ENQ: begin
                  // walk down from the tail, shifting lower priorities up
                  wr_en = 1'b1;
                  wr_addr = IdxW'(rptr_ff + 1'b1);
                  if (new_ff.prio > rd_data.prio) begin
                     wr_data = rd_data;
                     if (rptr_ff == '0) begin
                        state_in = S_TAIL;
                     end else begin
                        rptr_in = rptr_ff - 1'b1;
                     end
                  end else begin
                     wr_data = new_ff;
                     cnt_in = cnt_ff + 1'b1;
                     state_in = S_DONE;
                  end
               end
               ACT_PURGE: begin
                  if (rd_data.own != purge_own_ff) begin
                     wr_en = 1'b1;
                     wptr_in = wptr_ff + 1'b1;
                  end
                  if (last_entry) begin
                     cnt_in = wptr_in;
                     state_in = S_DONE;
                  end else begin
                     rptr_in = rptr_ff + 1'b1;
                  end
               end
               default: begin
                  // take the head, then shift the rest down
                  if (rptr_ff == '0) begin
                     slot_in = rd_data;
                     slot_valid_in = 1'b1;
                     time_in = TimeW'(rd_data.dur);
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = IdxW'(rptr_ff - 1'b1);
                  end
                  if (last_entry) begin
                     cnt_in = cnt_ff - 1'b1;
                     state_in = S_DONE;
                  end else begin
                     rptr_in = rptr_ff + 1'b1;
                  end
               end
            endcase
         end
         S_TAIL: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = new_ff;
            cnt_in = cnt_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            st_in.valid = slot_valid_ff;
            st_in.id = slot_valid_ff ? slot_ff.id : '0;
            st_in.once = slot_valid_ff & slot_ff.once;
            st_in.own = slot_valid_ff ? slot_ff.own : '0;
            rsp_valid_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         slot_valid_ff <= 1'b0;
         slot_ff <= '0;
         time_ff <= '0;
         done_mark_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         slot_valid_ff <= slot_valid_in;
         slot_ff <= slot_in;
         time_ff <= time_in;
         done_mark_ff <= done_mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      new_ff <= new_in;
      purge_own_ff <= purge_own_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      st_ff <= st_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_active_valid = st_ff.valid;
   assign rsp_active_id = st_ff.id;
   assign rsp_active_play_once = st_ff.once;
   assign rsp_active_owner = st_ff.own;
   assign rsp_queue_count = 5'(cnt_ff);
   assign rsp_dropped = st_ff.dropped;
   assign rsp_ended = st_ff.ended;
   assign rsp_started = st_ff.started;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntW'(QueueDepth))
      else $error("queue count above depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_started |-> rsp_active_valid)
      else $error("start without active job");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ended |-> !rsp_active_valid)
      else $error("end with active job");
endmodule

// ===== hdl/ptpq_store.sv =====
module ptpq_store import ptpq_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IdxW-1:0]     wr_addr,
   input  job_type             wr_data,
   input  logic [IdxW-1:0]     rd_addr,
   output job_type             rd_data
);
   job_type mem [QueueDepth];
   job_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench import ptpq_pkg::*; ();

   localparam int StallLimit = 20000;
   localparam int RandomItems = 1200;
   localparam int HoldCycles = 300;
   localparam logic [2:0] ActUnused = 3'd7;
   localparam logic signed [TimeW-1:0] TimeFloor = -(1 <<< (TimeW - 1));

   typedef struct packed {
      logic       valid;
      logic [7:0] id;
      logic       once;
      logic [1:0] own;
      logic [4:0] count;
      logic       dropped;
      logic       ended;
      logic       started;
   } expect_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  id;
      logic [23:0] dur;
      logic        once;
      logic [1:0]  own;
      logic [1:0]  prio;
      logic [15:0] elapsed;
      logic        done;
   } request_type;

   typedef struct {
      request_type req;
      logic        known;
      expect_type  status;
   } row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [2:0] req_action;
   logic [7:0] req_anim_id;
   logic [23:0] req_duration_ms;
   logic req_play_once;
   logic [1:0] req_owner;
   logic [1:0] req_priority_req;
   logic [15:0] req_elapsed_ms;
   logic req_done_flag;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_active_valid;
   logic [7:0] rsp_active_id;
   logic rsp_active_play_once;
   logic [1:0] rsp_active_owner;
   logic [4:0] rsp_queue_count;
   logic rsp_dropped;
   logic rsp_ended;
   logic rsp_started;

   job_type job_queue[$];
   logic slot_valid = 1'b0;
   job_type slot_job = '0;
   logic signed [TimeW-1:0] time_left = '0;
   logic done_mark = 1'b1;

   expect_type status_expected[$];
   expect_type last_got;
   int errors = 0;
   int typed_errors = 0;
   int accepted_reqs = 0;
   int checked_rsps = 0;
   int idle_cycles;
   int started_jobs = 0;
   int ended_jobs = 0;
   int dropped_jobs = 0;
   logic hold_start = 1'b0;
   logic hold_taken = 1'b0;

   priority_tagged_play_queue DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic expect_type play_step(request_type r);
      expect_type s;
      job_type j;
      job_type kept[$];
      int pos;
      logic signed [TimeW+1:0] t;
      s = '0;
      case (r.action)
         ACT_ENQ: begin
            j = '{id: r.id, dur: r.dur, once: r.once, own: r.own, prio: r.prio};
            if (job_queue.size() >= QueueDepth) begin
               s.dropped = 1'b1;
            end else begin
               pos = job_queue.size();
               foreach (job_queue[i]) begin
                  if (r.prio > job_queue[i].prio) begin
                     pos = i;
                     break;
                  end
               end
               job_queue.insert(pos, j);
            end
         end
         ACT_PURGE: begin
            foreach (job_queue[i]) if (job_queue[i].own != r.own) kept.push_back(job_queue[i]);
            job_queue = kept;
            if (slot_valid && slot_job.own == r.own) begin
               slot_valid = 1'b0;
               slot_job = '0;
               time_left = '0;
               done_mark = 1'b1;
            end
         end
         ACT_TICK: begin
            if (slot_valid) begin
               t = time_left - $signed({1'b0, r.elapsed});
               if (t < TimeFloor) t = TimeFloor;
               time_left = t[TimeW-1:0];
               if (t <= 0 || done_mark) begin
                  slot_valid = 1'b0;
                  done_mark = 1'b0;
                  s.ended = 1'b1;
               end
            end
         end
         ACT_START: begin
            if (!slot_valid && job_queue.size() > 0) begin
               slot_job = job_queue[0];
               job_queue.delete(0);
               slot_valid = 1'b1;
               time_left = $signed({2'b00, slot_job.dur});
               s.started = 1'b1;
            end
         end
         ACT_DONE: done_mark = r.done;
         default: ;
      endcase
      s.valid = slot_valid;
      s.id = slot_valid ? slot_job.id : 8'd0;
      s.once = slot_valid ? slot_job.once : 1'b0;
      s.own = slot_valid ? slot_job.own : 2'd0;
      s.count = 5'(job_queue.size());
      return s;
   endfunction

   function automatic request_type random_request();
      request_type r;
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      r = raw[$bits(request_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 40) r.action = ACT_ENQ;
      else if (pick < 47) r.action = ACT_PURGE;
      else if (pick < 72) r.action = ACT_TICK;
      else if (pick < 88) r.action = ACT_START;
      else if (pick < 96) r.action = ACT_DONE;
      else r.action = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 3) != 0) r.dur = 24'($urandom_range(0, 200000));
      if ($urandom_range(0, 2) != 0) r.elapsed = 16'($urandom_range(0, 3000));
      return r;
   endfunction

   task automatic send(request_type r);
      req_valid <= 1'b1;
      {req_action, req_anim_id, req_duration_ms, req_play_once, req_owner,
       req_priority_req, req_elapsed_ms, req_done_flag} <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (status_expected.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      expect_type got;
      expect_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            request_type r;
            r = {req_action, req_anim_id, req_duration_ms, req_play_once, req_owner,
                 req_priority_req, req_elapsed_ms, req_done_flag};
            want = play_step(r);
            status_expected.push_back(want);
            accepted_reqs++;
            if (want.started) started_jobs++;
            if (want.ended) ended_jobs++;
            if (want.dropped) dropped_jobs++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_active_valid, rsp_active_id, rsp_active_play_once, rsp_active_owner,
                   rsp_queue_count, rsp_dropped, rsp_ended, rsp_started};
            last_got = got;
            checked_rsps++;
            if (status_expected.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               want = status_expected[0];
               status_expected.delete(0);
               if (got !== want) begin
                  $display({"%0t: mismatch expected valid=%0d id=%0d once=%0d own=%0d",
                            " cnt=%0d drop=%0d end=%0d start=%0d"},
                           $time, want.valid, want.id, want.once, want.own, want.count,
                           want.dropped, want.ended, want.started);
                  $display({"%0t:          actual valid=%0d id=%0d once=%0d own=%0d",
                            " cnt=%0d drop=%0d end=%0d start=%0d"},
                           $time, got.valid, got.id, got.once, got.own, got.count,
                           got.dropped, got.ended, got.started);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("priority_tagged_play_queue regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         n = $urandom_range(0, 9);
         rsp_ready <= (n < 6) || (n == 9 && $urandom_range(0, 1) == 0) ? 1'b1 :
                      ($urandom_range(0, 1) == 0);
      end
   end

   initial begin
      row_type rows[$];
      request_type r;
      expect_type s;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_action, req_anim_id, req_duration_ms, req_play_once, req_owner,
       req_priority_req, req_elapsed_ms, req_done_flag} = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      r = '0; r.action = ACT_TICK;   r.elapsed = 16'hFFFF;
      rows.push_back('{r, 1'b1, expect_type'('0)});
      r = '0; r.action = ACT_START;
      rows.push_back('{r, 1'b1, expect_type'('0)});
      r = '0; r.action = ActUnused;
      rows.push_back('{r, 1'b1, expect_type'('0)});
      r = '0; r.action = ACT_PURGE;  r.own = 2'd3;
      rows.push_back('{r, 1'b1, expect_type'('0)});
      r = '0; r.action = ACT_ENQ; r.id = 8'hFF; r.dur = 24'hFFFFFF; r.once = 1'b1;
      r.own = 2'd3; r.prio = 2'd0;
      s = '0; s.count = 5'd1;
      rows.push_back('{r, 1'b1, s});
      r = '0; r.action = ACT_ENQ; r.id = 8'h00; r.dur = 24'd0; r.own = 2'd0; r.prio = 2'd3;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_ENQ; r.id = 8'h11; r.dur = 24'd5; r.own = 2'd1; r.prio = 2'd3;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_START;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_START;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_TICK; r.elapsed = 16'd0;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_START;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_DONE; r.done = 1'b0;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_TICK; r.elapsed = 16'd1;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_PURGE; r.own = 2'd1;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_START;
      rows.push_back('{r, 1'b0, s});
      r = '0; r.action = ACT_DONE; r.done = 1'b0;
      rows.push_back('{r, 1'b0, s});
      for (int k = 0; k < 5; k++) begin
         r = '0; r.action = ACT_TICK; r.elapsed = 16'hFFFF;
         rows.push_back('{r, 1'b0, s});
      end
      foreach (rows[i]) begin
         send(rows[i].req);
         if (rows[i].known) begin
            drain();
            if (last_got !== rows[i].status) begin
               $display("%0t: mismatch on directed row %0d expected %h actual %h",
                        $time, i, rows[i].status, last_got);
               typed_errors++;
            end
         end
      end
      drain();

      for (int k = 0; k < QueueDepth + 2; k++) begin
         r = random_request(); r.action = ACT_ENQ;
         send(r);
      end
      drain();
      hold_start = 1'b1;
      for (int k = 0; k < 8; k++) begin
         r = random_request(); r.action = ACT_ENQ;
         send(r);
      end
      drain();

      n_loop: for (int k = 0; k < RandomItems; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && k < RandomItems; b++, k++) send(random_request());
         if ($urandom_range(0, 2) == 0) gap();
      end
      drain();
      repeat (QueueDepth + 10) @(negedge clock);

      $display("covered %0d transactions, %0d checked: %0d starts, %0d ends, %0d drops",
               accepted_reqs, checked_rsps, started_jobs, ended_jobs, dropped_jobs);
      if (errors == 0 && typed_errors == 0 && status_expected.size() == 0)
         $display("priority_tagged_play_queue regression: pass");
      else
         $display("priority_tagged_play_queue regression: fail");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/ptpq_pkg.sv
hdl/ptpq_store.sv
hdl/priority_tagged_play_queue.sv
tb/testbench.sv
